### sv/qvu_pkg.sv
// Shared types, constants and register codes for the Q value update engine.
package qvu_pkg;

    // Entry format: signed Q8.8
    localparam int Q_W = 16;
    // Configuration register data width and index width
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    // Default table geometry
    localparam int DEF_NUM_STATES  = 64;
    localparam int DEF_NUM_ACTIONS = 6;

    // Datapath widths: difference term (scaled by 2^16) and product (scaled by 2^24)
    localparam int D_W = 26;
    localparam int P_W = 36;
    // Rounded increment and the sum before clamping
    localparam int INC_W = P_W - 16;
    localparam int S_W   = INC_W + 1;

    // Register reset values
    localparam logic [CFG_W-1:0] LR_RESET   = 9'd77;
    localparam logic [CFG_W-1:0] DF_RESET   = 9'd128;

    // Update modes
    localparam logic MODE_QLEARN = 1'b0;
    localparam logic MODE_SARSA  = 1'b1;
    localparam logic MODE_RESET  = MODE_QLEARN;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARNING_RATE   = 2'd0,
        CFG_DISCOUNT_FACTOR = 2'd1,
        CFG_UPDATE_MODE     = 2'd2
    } cfg_reg_e_t;

    // Stage load enables from the sequencer to the arithmetic unit
    typedef struct packed {
        logic pick_en;
        logic diff_en;
        logic prod_en;
    } qvu_ctrl_t;

endpackage

### sv/qvu_table.sv
// Q table memory: one row per state, two registered read ports, one write port, clear sweep.
module qvu_table #(
    parameter int NUM_STATES  = qvu_pkg::DEF_NUM_STATES,
    parameter int NUM_ACTIONS = qvu_pkg::DEF_NUM_ACTIONS
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        rd_en,
    input  logic [$clog2(NUM_STATES)-1:0]               rd_addr_cur,
    input  logic [$clog2(NUM_STATES)-1:0]               rd_addr_next,
    output logic [NUM_ACTIONS-1:0][qvu_pkg::Q_W-1:0]    rd_row_cur,
    output logic [NUM_ACTIONS-1:0][qvu_pkg::Q_W-1:0]    rd_row_next,
    input  logic                                        wr_en,
    input  logic [$clog2(NUM_STATES)-1:0]               wr_addr,
    input  logic [NUM_ACTIONS-1:0][qvu_pkg::Q_W-1:0]    wr_row,
    output logic                                        clear_busy
);
    import qvu_pkg::*;

    localparam int SA_W = $clog2(NUM_STATES);
    localparam logic [SA_W-1:0] LAST_ROW = SA_W'(NUM_STATES - 1);

    typedef logic [NUM_ACTIONS-1:0][Q_W-1:0] row_t;

    row_t mem [NUM_STATES];

    logic            clear_active_reg, clear_active_next;
    logic [SA_W-1:0] clear_addr_reg, clear_addr_next;
    row_t            rd_cur_reg, rd_next_reg;

    logic            mem_we;
    logic [SA_W-1:0] mem_waddr;
    row_t            mem_wdata;

    // Clear sweep after reset, one row per cycle
    always_comb
    begin
        clear_active_next = clear_active_reg;
        clear_addr_next   = clear_addr_reg;
        if (clear_active_reg)
        begin
            clear_addr_next = clear_addr_reg + SA_W'(1);
            if (clear_addr_reg == LAST_ROW)
            begin
                clear_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else
        begin
            clear_active_reg <= clear_active_next;
            clear_addr_reg   <= clear_addr_next;
        end
    end

    // Write port: sweep has priority
    always_comb
    begin
        mem_we    = clear_active_reg | wr_en;
        mem_waddr = clear_active_reg ? clear_addr_reg : wr_addr;
        mem_wdata = clear_active_reg ? '0 : wr_row;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Registered reads, held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_cur_reg  <= mem[rd_addr_cur];
            rd_next_reg <= mem[rd_addr_next];
        end
    end

    assign rd_row_cur  = rd_cur_reg;
    assign rd_row_next = rd_next_reg;
    assign clear_busy  = clear_active_reg;

endmodule

### sv/qvu_update.sv
// Update arithmetic: target pick, gamma and alpha multiplies, rounding and clamping.
module qvu_update #(
    parameter int NUM_ACTIONS = qvu_pkg::DEF_NUM_ACTIONS
) (
    input  logic                                        clk,
    input  qvu_pkg::qvu_ctrl_t                          ctrl,
    input  logic                                        mode,
    input  logic                                        cur_ok,
    input  logic                                        next_ok,
    input  logic [$clog2(NUM_ACTIONS)-1:0]              action,
    input  logic [$clog2(NUM_ACTIONS)-1:0]              next_action,
    input  logic [NUM_ACTIONS-1:0]                      next_mask,
    input  logic signed [qvu_pkg::Q_W-1:0]              reward,
    input  logic [qvu_pkg::CFG_W-1:0]                   alpha,
    input  logic [qvu_pkg::CFG_W-1:0]                   gamma,
    input  logic [NUM_ACTIONS-1:0][qvu_pkg::Q_W-1:0]    row_cur,
    input  logic [NUM_ACTIONS-1:0][qvu_pkg::Q_W-1:0]    row_next,
    output logic signed [qvu_pkg::Q_W-1:0]              result
);
    import qvu_pkg::*;

    localparam int ACT_W  = $clog2(NUM_ACTIONS);
    localparam int LEAVES = 1 << ACT_W;
    localparam logic [ACT_W:0] ACT_LIM = (ACT_W + 1)'(NUM_ACTIONS);
    localparam logic signed [P_W-1:0] RND_HALF = P_W'(32'sd32768);
    localparam logic signed [S_W-1:0] SAT_HI   = S_W'(32'sd32767);
    localparam logic signed [S_W-1:0] SAT_LO   = S_W'(-32'sd32768);

    // Max tree over the masked next-state row, heap order (root at node 0)
    logic                 node_v [2*LEAVES-1];
    logic signed [Q_W-1:0] node_q [2*LEAVES-1];

    genvar gi;
    generate
        for (gi = 0; gi < LEAVES; gi++)
        begin : g_leaf
            if (gi < NUM_ACTIONS)
            begin : g_used
                assign node_v[LEAVES-1+gi] = next_mask[gi];
                assign node_q[LEAVES-1+gi] = row_next[gi];
            end
            else
            begin : g_pad
                assign node_v[LEAVES-1+gi] = 1'b0;
                assign node_q[LEAVES-1+gi] = '0;
            end
        end
        for (gi = 0; gi < LEAVES - 1; gi++)
        begin : g_node
            logic take_right;
            assign take_right = node_v[2*gi+2] &&
                                (!node_v[2*gi+1] || (node_q[2*gi+2] > node_q[2*gi+1]));
            assign node_v[gi] = node_v[2*gi+1] | node_v[2*gi+2];
            assign node_q[gi] = take_right ? node_q[2*gi+2] : node_q[2*gi+1];
        end
    endgenerate

    logic signed [Q_W-1:0] q_sel, target_sel;
    logic                  next_act_ok;

    // Current entry and target selection
    always_comb
    begin
        next_act_ok = ({1'b0, next_action} < ACT_LIM);
        q_sel       = cur_ok ? $signed(row_cur[action]) : '0;
        target_sel  = '0;
        if (next_ok)
        begin
            if (mode == MODE_SARSA)
            begin
                if (next_act_ok)
                begin
                    target_sel = $signed(row_next[next_action]);
                end
            end
            else if (node_v[0])
            begin
                target_sel = node_q[0];
            end
        end
    end

    logic signed [Q_W-1:0] q_reg, target_reg;
    logic signed [D_W-1:0] d_reg, d_next;
    logic signed [P_W-1:0] p_reg, p_next;

    // Difference term r*256 + gamma*target - q*256, exact in D_W bits
    always_comb
    begin
        logic signed [D_W-1:0] r_sc;
        logic signed [D_W-1:0] q_sc;
        logic signed [D_W-1:0] g_t;
        r_sc   = D_W'(reward) <<< 8;
        q_sc   = D_W'(q_reg) <<< 8;
        g_t    = $signed({1'b0, gamma}) * target_reg;
        d_next = r_sc + g_t - q_sc;
    end

    // Scale by alpha
    assign p_next = $signed({1'b0, alpha}) * d_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.pick_en)
        begin
            q_reg      <= q_sel;
            target_reg <= target_sel;
        end
        if (ctrl.diff_en)
        begin
            d_reg <= d_next;
        end
        if (ctrl.prod_en)
        begin
            p_reg <= p_next;
        end
    end

    // Round half up to Q8.8, add to q, clamp to 16 bits; result is zero when the current entry is invalid
    always_comb
    begin
        logic signed [P_W-1:0]   rnd;
        logic signed [INC_W-1:0] inc;
        logic signed [S_W-1:0]   sum;
        rnd = p_reg + RND_HALF;
        inc = rnd[P_W-1:16];
        sum = S_W'(q_reg) + S_W'(inc);
        if (!cur_ok)
        begin
            result = '0;
        end
        else if (sum > SAT_HI)
        begin
            result = Q_W'(SAT_HI);
        end
        else if (sum < SAT_LO)
        begin
            result = Q_W'(SAT_LO);
        end
        else
        begin
            result = Q_W'(sum);
        end
    end

endmodule

### sv/q_value_update_engine.sv
// Q value update engine: tabular Q-learning / SARSA update, top level.
// Sequence: the table read happens at the accept edge, then target pick, gamma multiply,
//   alpha multiply, round/clamp and write-back; write-back waits while the output stalls.
// One word is in flight at a time: the read-modify-write of one table row runs through
//   the two multiply stages, and the next word's read follows the previous write.
// Reset: asynchronous, active low; registers return to their defaults and the table is
//   swept to zero, one row per cycle, while input is held off.
module q_value_update_engine #(
    parameter int NUM_STATES  = qvu_pkg::DEF_NUM_STATES,
    parameter int NUM_ACTIONS = qvu_pkg::DEF_NUM_ACTIONS,
    localparam int SA_W       = $clog2(NUM_STATES),
    localparam int ACT_W      = $clog2(NUM_ACTIONS),
    localparam int IN_BITS    = 2 * SA_W + 2 * ACT_W + qvu_pkg::Q_W + NUM_ACTIONS,
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port
    input  logic                          cfg_write_en,
    input  logic [qvu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [qvu_pkg::CFG_W-1:0]     cfg_data,
    // Input words
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // state_index, action_index, reward_value, next_state_index, next_valid_mask,
    // next_action_index, zero fill (lowest bit first)
    input  logic [IN_TDATA_W-1:0]         s_axis_tdata,
    // Result words
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // updated_value
    output logic [qvu_pkg::Q_W-1:0]       m_axis_tdata
);
    import qvu_pkg::*;

    localparam logic [SA_W:0]  ST_LIM  = (SA_W + 1)'(NUM_STATES);
    localparam logic [ACT_W:0] ACT_LIM = (ACT_W + 1)'(NUM_ACTIONS);

    // Field offsets in s_axis_tdata
    localparam int OFS_ACT  = SA_W;
    localparam int OFS_REW  = OFS_ACT + ACT_W;
    localparam int OFS_NS   = OFS_REW + Q_W;
    localparam int OFS_MASK = OFS_NS + SA_W;
    localparam int OFS_NA   = OFS_MASK + NUM_ACTIONS;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PICK  = 5'b00010,
        ST_DIFF  = 5'b00100,
        ST_PROD  = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    typedef logic [NUM_ACTIONS-1:0][Q_W-1:0] row_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [CFG_W-1:0] learning_rate_reg, learning_rate_next;
    logic [CFG_W-1:0] discount_factor_reg, discount_factor_next;
    logic             update_mode_reg, update_mode_next;

    // Captured input word
    logic [SA_W-1:0]        st_reg;
    logic [ACT_W-1:0]       act_reg;
    logic signed [Q_W-1:0]  reward_reg;
    logic [NUM_ACTIONS-1:0] mask_reg;
    logic [ACT_W-1:0]       next_act_reg;
    logic                   cur_ok_reg;
    logic                   next_ok_reg;

    // Output register
    logic           out_valid_reg, out_valid_next;
    logic [Q_W-1:0] out_data_reg;

    logic                  in_fire, out_free, write_go, clear_busy;
    logic [SA_W-1:0]       in_st, in_ns;
    logic [ACT_W-1:0]      in_act;
    row_t                  row_cur, row_next, wr_row;
    logic signed [Q_W-1:0] upd_result;
    qvu_ctrl_t             ctrl;

    assign in_st  = s_axis_tdata[SA_W-1:0];
    assign in_act = s_axis_tdata[OFS_ACT +: ACT_W];
    assign in_ns  = s_axis_tdata[OFS_NS +: SA_W];

    assign s_axis_tready = (state_reg == ST_IDLE) && !clear_busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign write_go      = (state_reg == ST_WRITE) && out_free;

    // Configuration writes
    always_comb
    begin
        learning_rate_next   = learning_rate_reg;
        discount_factor_next = discount_factor_reg;
        update_mode_next     = update_mode_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_LEARNING_RATE:   learning_rate_next   = cfg_data;
                CFG_DISCOUNT_FACTOR: discount_factor_next = cfg_data;
                CFG_UPDATE_MODE:     update_mode_next     = cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                ctrl.pick_en = 1'b1;
                state_next   = ST_DIFF;
            end
            ST_DIFF:
            begin
                ctrl.diff_en = 1'b1;
                state_next   = ST_PROD;
            end
            ST_PROD:
            begin
                ctrl.prod_en = 1'b1;
                state_next   = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (write_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            learning_rate_reg   <= LR_RESET;
            discount_factor_reg <= DF_RESET;
            update_mode_reg     <= MODE_RESET;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            learning_rate_reg   <= learning_rate_next;
            discount_factor_reg <= discount_factor_next;
            update_mode_reg     <= update_mode_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Input capture and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            st_reg       <= in_st;
            act_reg      <= in_act;
            reward_reg   <= $signed(s_axis_tdata[OFS_REW +: Q_W]);
            mask_reg     <= s_axis_tdata[OFS_MASK +: NUM_ACTIONS];
            next_act_reg <= s_axis_tdata[OFS_NA +: ACT_W];
            cur_ok_reg   <= ({1'b0, in_st} < ST_LIM) && ({1'b0, in_act} < ACT_LIM);
            next_ok_reg  <= ({1'b0, in_ns} < ST_LIM);
        end
        if (write_go)
        begin
            out_data_reg <= upd_result;
        end
    end

    // Row write-back with the updated entry replaced
    always_comb
    begin
        wr_row          = row_cur;
        wr_row[act_reg] = upd_result;
    end

    qvu_table #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_en        (in_fire),
        .rd_addr_cur  (in_st),
        .rd_addr_next (in_ns),
        .rd_row_cur   (row_cur),
        .rd_row_next  (row_next),
        .wr_en        (write_go && cur_ok_reg),
        .wr_addr      (st_reg),
        .wr_row       (wr_row),
        .clear_busy   (clear_busy)
    );

    qvu_update #(
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_update (
        .clk         (clk),
        .ctrl        (ctrl),
        .mode        (update_mode_reg),
        .cur_ok      (cur_ok_reg),
        .next_ok     (next_ok_reg),
        .action      (act_reg),
        .next_action (next_act_reg),
        .next_mask   (mask_reg),
        .reward      (reward_reg),
        .alpha       (learning_rate_reg),
        .gamma       (discount_factor_reg),
        .row_cur     (row_cur),
        .row_next    (row_next),
        .result      (upd_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // An accepted word starts the target pick in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_PICK))
        else $error("accepted word did not enter target pick");

    // No input is taken while the table is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !s_axis_tready)
        else $error("input ready during table clear");

    // A result only appears after the write-back step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_WRITE))
        else $error("result raised outside write-back");

    // Every write-back presents its result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        write_go |=> m_axis_tvalid)
        else $error("write-back without result");

endmodule
